>>> hdl/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg: shared types and constants of the half-step sequencer
// Holds the move state record, the result record, the status and operation
// codes, and the eight-entry half-step coil pattern.
// ----------------------------------------------------------------------------
package shs_pkg;

  localparam int PHASE_COUNT = 8;
  localparam int COIL_COUNT  = 4;
  localparam int PHASE_W     = $clog2(PHASE_COUNT);

  localparam int OP_W        = 2;
  localparam int DIR_W       = 2;
  localparam int STEPS_W     = 16;
  localparam int INTERVAL_W  = 18;
  localparam int COUNT_W     = 14;
  localparam int CFG_DATA_W  = 18;
  localparam int CFG_INDEX_W = 2;
  localparam int STATUS_W    = 3;

  localparam logic [OP_W-1:0] OP_COMMAND = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
  localparam logic [OP_W-1:0] OP_ABORT   = 2'd2;

  localparam logic signed [DIR_W-1:0] DIR_FORWARD = 2'sb01;
  localparam logic signed [DIR_W-1:0] DIR_REVERSE = 2'sb11;

  localparam logic [CFG_INDEX_W-1:0] REG_MIN_INTERVAL = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_INTERVAL = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_STEPS    = 2'd2;

  localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RESET = 18'd500;
  localparam logic [INTERVAL_W-1:0] MAX_INTERVAL_RESET = 18'd100000;
  localparam logic [COUNT_W-1:0]    MAX_STEPS_RESET    = 14'd8192;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_NONE      = 3'd0,
    STATUS_ACCEPTED  = 3'd1,
    STATUS_INVALID   = 3'd2,
    STATUS_BUSY      = 3'd3,
    STATUS_COMPLETED = 3'd4,
    STATUS_ABORTED   = 3'd5
  } status_t;

  typedef struct packed {
    logic [PHASE_W-1:0]    phase_index;
    logic [COUNT_W-1:0]    steps_left;
    logic [INTERVAL_W-1:0] tick_count;
    logic [INTERVAL_W-1:0] interval_hold;
    logic                  reverse_dir;
    logic                  running;
    logic [COIL_COUNT-1:0] coil_drive;
  } motor_state_t;

  typedef struct packed {
    logic [COIL_COUNT-1:0] coils;
    logic                  busy_res;
    status_t               status;
  } result_t;

  typedef struct packed {
    logic [INTERVAL_W-1:0] min_interval;
    logic [INTERVAL_W-1:0] max_interval;
    logic [COUNT_W-1:0]    max_steps;
  } limits_t;

  function automatic logic [COIL_COUNT-1:0] half_step_pattern(input logic [PHASE_W-1:0] idx);
    logic [COIL_COUNT-1:0] pat;
    case (idx)
      3'd0:    pat = 4'h2;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h1;
      3'd3:    pat = 4'h9;
      3'd4:    pat = 4'h8;
      3'd5:    pat = 4'hc;
      3'd6:    pat = 4'h4;
      3'd7:    pat = 4'h6;
      default: pat = '0;
    endcase
    return pat;
  endfunction

endpackage

>>> hdl/stepper_half_step_sequencer_core.sv
// ----------------------------------------------------------------------------
// stepper_half_step_sequencer_core: half-step sequencer for a unipolar stepper
// path: an input transaction passes through the input register, then the
// next-state logic into the result register
// throughput: one transaction per cycle while in_stall is low
// a two-entry result buffer lets input keep flowing while a result waits
// reset: synchronous; coil drive off, idle, phase 0, limits at their defaults
// ----------------------------------------------------------------------------
module stepper_half_step_sequencer_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [shs_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [shs_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [shs_pkg::OP_W-1:0]            op,
  input  logic signed [shs_pkg::DIR_W-1:0]    direction,
  input  logic [shs_pkg::STEPS_W-1:0]         steps,
  input  logic [shs_pkg::INTERVAL_W-1:0]      interval,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [shs_pkg::COIL_COUNT-1:0]      coils,
  output logic                                busy_res,
  output logic [shs_pkg::STATUS_W-1:0]        status
);
  import shs_pkg::*;

  limits_t                      limits;
  motor_state_t                 state;
  motor_state_t                 state_next;
  result_t                      step_result;

  logic                         in_reg_valid;
  logic [OP_W-1:0]              in_reg_op;
  logic signed [DIR_W-1:0]      in_reg_direction;
  logic [STEPS_W-1:0]           in_reg_steps;
  logic [INTERVAL_W-1:0]        in_reg_interval;

  result_t                      out_reg;
  result_t                      skid_reg;
  logic                         skid_valid;
  logic                         exec_fire;
  logic                         out_take;

  assign in_stall  = in_reg_valid && skid_valid;
  assign exec_fire = in_reg_valid && !skid_valid;
  assign out_take  = out_valid && !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.min_interval <= MIN_INTERVAL_RESET;
      limits.max_interval <= MAX_INTERVAL_RESET;
      limits.max_steps    <= MAX_STEPS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MIN_INTERVAL: limits.min_interval <= cfg_data[INTERVAL_W-1:0];
        REG_MAX_INTERVAL: limits.max_interval <= cfg_data[INTERVAL_W-1:0];
        REG_MAX_STEPS:    limits.max_steps    <= cfg_data[COUNT_W-1:0];
        default:          limits              <= limits;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_reg_op        <= op;
      in_reg_direction <= direction;
      in_reg_steps     <= steps;
      in_reg_interval  <= interval;
    end
  end

  shs_step u_step (
    .state      (state),
    .limits     (limits),
    .op         (in_reg_op),
    .direction  (in_reg_direction),
    .steps      (in_reg_steps),
    .interval   (in_reg_interval),
    .state_next (state_next),
    .result     (step_result)
  );

  // move state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (exec_fire) begin
      state <= state_next;
    end
  end

  // result register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (exec_fire) begin
        if (!out_valid || out_take) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid  <= skid_valid;
        skid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      if (!out_valid || out_take) begin
        out_reg <= step_result;
      end else begin
        skid_reg <= step_result;
      end
    end else if (out_take && skid_valid) begin
      out_reg <= skid_reg;
    end
  end

  assign coils    = out_reg.coils;
  assign busy_res = out_reg.busy_res;
  assign status   = out_reg.status;

endmodule

>>> hdl/shs_step.sv
// ----------------------------------------------------------------------------
// shs_step: next-state logic of the half-step sequencer
// Checks a move command against the limits, counts ticks, advances the phase
// and handles aborts, giving the next move state and one result record.
// ----------------------------------------------------------------------------
module shs_step (
  input  shs_pkg::motor_state_t                  state,
  input  shs_pkg::limits_t                       limits,
  input  logic [shs_pkg::OP_W-1:0]               op,
  input  logic signed [shs_pkg::DIR_W-1:0]       direction,
  input  logic [shs_pkg::STEPS_W-1:0]            steps,
  input  logic [shs_pkg::INTERVAL_W-1:0]         interval,
  output shs_pkg::motor_state_t                  state_next,
  output shs_pkg::result_t                       result
);
  import shs_pkg::*;

  logic                  dir_ok;
  logic                  steps_ok;
  logic                  int_ok;
  logic [INTERVAL_W-1:0] tick_inc;
  logic [COUNT_W-1:0]    steps_dec;
  logic [PHASE_W-1:0]    phase_fwd;
  logic [PHASE_W-1:0]    phase_rev;
  status_t               status;

  assign dir_ok    = (direction == DIR_FORWARD) || (direction == DIR_REVERSE);
  assign steps_ok  = (steps != '0) && (steps <= STEPS_W'(limits.max_steps));
  assign int_ok    = (interval >= limits.min_interval) && (interval <= limits.max_interval);
  assign tick_inc  = state.tick_count + INTERVAL_W'(1);
  assign steps_dec = state.steps_left - COUNT_W'(1);
  assign phase_fwd = state.phase_index + PHASE_W'(1);
  assign phase_rev = state.phase_index - PHASE_W'(1);

  always_comb begin
    state_next = state;
    status     = STATUS_NONE;
    case (op)
      OP_COMMAND: begin
        if (state.running) begin
          status = STATUS_BUSY;
        end else if (!dir_ok || !steps_ok || !int_ok) begin
          status = STATUS_INVALID;
        end else begin
          state_next.reverse_dir   = (direction == DIR_REVERSE);
          state_next.steps_left    = steps[COUNT_W-1:0];
          state_next.interval_hold = interval;
          state_next.tick_count    = '0;
          state_next.running       = 1'b1;
          state_next.coil_drive    = half_step_pattern(state.phase_index);
          state_next.phase_index   = (direction == DIR_REVERSE) ? phase_rev : phase_fwd;
          status = STATUS_ACCEPTED;
        end
      end
      OP_TICK: begin
        if (state.running) begin
          if (tick_inc >= state.interval_hold) begin
            state_next.tick_count = '0;
            state_next.steps_left = steps_dec;
            if (steps_dec == '0) begin
              state_next.running    = 1'b0;
              state_next.coil_drive = '0;
              status = STATUS_COMPLETED;
            end else begin
              state_next.coil_drive  = half_step_pattern(state.phase_index);
              state_next.phase_index = state.reverse_dir ? phase_rev : phase_fwd;
            end
          end else begin
            state_next.tick_count = tick_inc;
          end
        end
      end
      OP_ABORT: begin
        if (state.running) begin
          state_next.running    = 1'b0;
          state_next.coil_drive = '0;
          state_next.steps_left = '0;
          state_next.tick_count = '0;
          status = STATUS_ABORTED;
        end
      end
      default: begin
        status = STATUS_NONE;
      end
    endcase
  end

  assign result.coils    = state_next.coil_drive;
  assign result.busy_res = state_next.running;
  assign result.status   = status;

endmodule
